// File: hw/rtl/line_cylinder_tessellator_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line cylinder tessellator
// Clocked implication checks, same-cycle and next-cycle forms.
// ---------------------------------------------------------------------------
`ifndef LINE_CYLINDER_TESSELLATOR_TOP_ASSERT_SVH
`define LINE_CYLINDER_TESSELLATOR_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define LCT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lct: same-cycle check failed");

// ante implies cons in the next cycle
`define LCT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lct: next-cycle check failed");

`endif

// File: hw/rtl/lct_pkg.sv
// ---------------------------------------------------------------------------
// lct_pkg
// Shared constants, types and small functions of the cylinder tessellator.
// ---------------------------------------------------------------------------
package lct_pkg;

  localparam int MAX_SUBDIV_DEF  = 32;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int SUBDIV_W    = 6;
  localparam int COLOR_W     = 32;
  localparam int RADIUS_W    = 31;
  localparam int VNUM_W      = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int UNIT_ONE     = 16384;
  localparam int UNIT_W       = 16;
  localparam int CORDIC_STEPS = 15;
  localparam int CORDIC_X0    = 652032874;
  localparam int XY_W         = 34;
  localparam int XY1_W        = XY_W + 1;
  localparam int Z_W          = 16;
  localparam int MUL_W        = 32;
  localparam int PROD_W       = 64;
  localparam int DIV_W        = 48;
  localparam int QUO_W        = 17;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SUBDIVISIONS = 2'd0,
    REG_VERTEX_COLOR = 2'd1
  } cfg_reg_t;

  typedef logic signed [UNIT_W-1:0] unit_t;

  // arctangent of 2^-k in 2^-16 turn
  function automatic logic signed [Z_W-1:0] atan_turn(input logic [3:0] k);
    logic signed [Z_W-1:0] v;
    case (k)
      4'd0:    v = 16'sd8192;
      4'd1:    v = 16'sd4836;
      4'd2:    v = 16'sd2555;
      4'd3:    v = 16'sd1297;
      4'd4:    v = 16'sd651;
      4'd5:    v = 16'sd326;
      4'd6:    v = 16'sd163;
      4'd7:    v = 16'sd81;
      4'd8:    v = 16'sd41;
      4'd9:    v = 16'sd20;
      4'd10:   v = 16'sd10;
      4'd11:   v = 16'sd5;
      4'd12:   v = 16'sd3;
      4'd13:   v = 16'sd1;
      4'd14:   v = 16'sd1;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Q1.30 to Q2.14, round half up, clamp to +-1.0
  function automatic unit_t to_q14(input logic signed [XY_W-1:0] v);
    logic signed [XY1_W-1:0] r;
    r = (XY1_W'(v) + XY1_W'(32768)) >>> 16;
    if (r > XY1_W'(UNIT_ONE)) r = XY1_W'(UNIT_ONE);
    if (r < -XY1_W'(UNIT_ONE)) r = -XY1_W'(UNIT_ONE);
    return UNIT_W'(r);
  endfunction

  // next component index, modulo three
  function automatic logic [1:0] next3(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

endpackage

// File: hw/rtl/line_cylinder_tessellator_top.sv
// ---------------------------------------------------------------------------
// line_cylinder_tessellator_top
// Turns one line segment into the ring vertices of an open cylinder.
// ---------------------------------------------------------------------------
// One segment word (two endpoints and a radius, Q16.16) yields two rings of N
// vertices each, interleaved start/end per ring step, each with the
// configured color; a segment with no usable basis yields a single word
// flagged degenerate. All arithmetic runs through one 32x32 multiplier, a
// shift/compare unit and a radix-2 divider under one sequencer, so the block
// takes one segment at a time and holds seg_stall high until it has queued the
// last vertex. Per segment: three vector normalizations, each one bit-serial
// scaling pass (one bit a cycle), three squaring multiplies, a square root
// and three divides; two cross products; a phase divide; then per ring step
// a 15-step CORDIC, the offset multiplies and two output words, with N = 8
// by default. Vertex output waits while vtx_stall is held.
// Config writes (subdivisions, vertex_color) are only to be issued while
// the block is idle; subdivisions of zero act as one, values above
// MAX_SUBDIVISIONS clamp to it.
// ---------------------------------------------------------------------------
`include "line_cylinder_tessellator_top_assert.svh"

module line_cylinder_tessellator_top #(
  parameter int MAX_SUBDIVISIONS = lct_pkg::MAX_SUBDIV_DEF,
  parameter int COORD_WIDTH      = lct_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_write,
  input  logic [lct_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lct_pkg::CFG_DATA_W-1:0]      cfg_data,
  // segment channel
  input  logic                                seg_valid,
  output logic                                seg_stall,
  input  logic signed [COORD_WIDTH-1:0]       start_x,
  input  logic signed [COORD_WIDTH-1:0]       start_y,
  input  logic signed [COORD_WIDTH-1:0]       start_z,
  input  logic signed [COORD_WIDTH-1:0]       end_x,
  input  logic signed [COORD_WIDTH-1:0]       end_y,
  input  logic signed [COORD_WIDTH-1:0]       end_z,
  input  logic [lct_pkg::RADIUS_W-1:0]        tube_radius,
  // vertex channel
  output logic                                vtx_valid,
  input  logic                                vtx_stall,
  output logic signed [COORD_WIDTH-1:0]       pos_x,
  output logic signed [COORD_WIDTH-1:0]       pos_y,
  output logic signed [COORD_WIDTH-1:0]       pos_z,
  output logic [lct_pkg::VNUM_W-1:0]          vertex_number,
  output logic [lct_pkg::COLOR_W-1:0]         color_out,
  output logic                                degenerate,
  output logic                                last
);
  import lct_pkg::*;

  // widths that follow from the parameters
  localparam int NW    = $clog2(MAX_SUBDIVISIONS + 1);   // ring count / index
  localparam int NXW   = NW + SUBDIV_W;                   // clamp compare
  localparam int MW    = (COORD_WIDTH + 1 > 31) ? COORD_WIDTH + 1 : 31;  // magnitudes
  localparam int VW    = MW + 1;                          // signed vector parts
  localparam int OFF_W = 36;                              // ring offset
  localparam int SW    = ((COORD_WIDTH > OFF_W) ? COORD_WIDTH : OFF_W) + 1;

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_ABS   = 21'h000002,
    S_NORM  = 21'h000004,
    S_SQM   = 21'h000008,
    S_SQA   = 21'h000010,
    S_SQRT  = 21'h000020,
    S_DIVI  = 21'h000040,
    S_DIV   = 21'h000080,
    S_CRM   = 21'h000100,
    S_CRA   = 21'h000200,
    S_CORI  = 21'h000400,
    S_COR   = 21'h000800,
    S_CORF  = 21'h001000,
    S_OFM   = 21'h002000,
    S_OFT   = 21'h004000,
    S_OFS   = 21'h008000,
    S_OFR   = 21'h010000,
    S_OFW   = 21'h020000,
    S_OUT0  = 21'h040000,
    S_OUT1  = 21'h080000,
    S_DEGEN = 21'h100000
  } state_t;

  // which vector the normalizer is working on
  typedef enum logic [1:0] {
    V_DIR = 2'd0,
    V_B1  = 2'd1,
    V_B2  = 2'd2
  } vsel_t;

  // config registers
  logic [SUBDIV_W-1:0] subdivisions;
  logic [COLOR_W-1:0]  vertex_color;

  state_t state;
  vsel_t  sel;

  // segment
  logic signed [COORD_WIDTH-1:0] pa [3];
  logic signed [COORD_WIDTH-1:0] pb [3];
  logic [RADIUS_W-1:0]           rad;

  // normalizer
  logic signed [VW-1:0] vin [3];
  logic [MW-1:0]        m [3];
  logic                 neg [3];
  logic [1:0]           cidx;
  logic                 term;
  logic [PROD_W-1:0]    sum_sq;
  logic [63:0]          sq_src;
  logic [35:0]          sq_rem;
  logic [31:0]          sq_res;
  logic [4:0]           sq_cnt;
  logic [31:0]          len;

  // shared divider
  logic [DIV_W-1:0] div_rem;
  logic [DIV_W-1:0] div_dsh;
  logic [QUO_W-1:0] div_q;
  logic [4:0]       div_cnt;
  logic             div_phase;

  // basis
  unit_t vn [3];
  unit_t b1 [3];
  unit_t b2 [3];

  // ring phase, kept as running quotient and remainder
  logic [QUO_W-1:0] ph_q0, ph_q;
  logic [NW-1:0]    ph_r0, ph_r;
  logic [NW-1:0]    ring_i;
  logic [NW-1:0]    n_eff;

  // CORDIC
  logic signed [XY_W-1:0] cx, cy;
  logic signed [Z_W-1:0]  cz;
  logic [3:0]             ck;
  logic [1:0]             quad;
  unit_t                  s_val, c_val;

  // offsets
  logic signed [31:0]      t_acc;
  logic signed [OFF_W-1:0] off [3];

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // combinational helpers
  logic [MW-1:0]          mx;
  logic                   out_free;
  logic                   vtx_send;
  logic [1:0]             cr_i1, cr_i2, ua_i, vb_i;
  unit_t                  cr_u, cr_v;
  logic [35:0]            rem_sh, sq_trial;
  logic                   sq_ge;
  logic                   div_ge;
  logic [DIV_W-1:0]       div_rem_nx;
  logic [QUO_W-1:0]       div_q_nx;
  unit_t                  div_unit;
  logic signed [XY_W-1:0] sh_x, sh_y;
  unit_t                  cs_q, sn_q;
  logic [NW:0]            ph_sum;

  function automatic logic signed [COORD_WIDTH-1:0] sat_add(
    input logic signed [COORD_WIDTH-1:0] e,
    input logic signed [OFF_W-1:0]       o
  );
    logic signed [SW-1:0] s;
    s = SW'(e) + SW'(o);
    if ((&s[SW-1:COORD_WIDTH-1]) || !(|s[SW-1:COORD_WIDTH-1]))
      return s[COORD_WIDTH-1:0];
    else if (s[SW-1])
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    else
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
  endfunction

  assign seg_stall = (state != S_IDLE);
  assign out_free  = !vtx_valid || !vtx_stall;
  // a vertex word is loaded into the output register this cycle
  assign vtx_send  = out_free &&
                     ((state == S_OUT0) || (state == S_OUT1) || (state == S_DEGEN));

  always_comb begin
    if (subdivisions == '0)
      n_eff = NW'(1);
    else if (NXW'(subdivisions) > NXW'(MAX_SUBDIVISIONS))
      n_eff = NW'(MAX_SUBDIVISIONS);
    else
      n_eff = NW'(subdivisions);
  end

  always_comb begin
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
  end

  // cross product operands: u x v, v = rotated vn or b1
  always_comb begin
    cr_i1 = next3(cidx);
    cr_i2 = next3(cr_i1);
    ua_i  = term ? cr_i2 : cr_i1;
    vb_i  = term ? cr_i1 : cr_i2;
    cr_u  = vn[ua_i];
    cr_v  = (sel == V_DIR) ? vn[next3(vb_i)] : b1[vb_i];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQM: begin
        mul_a = MUL_W'({1'b0, m[cidx][29:0]});
        mul_b = MUL_W'({1'b0, m[cidx][29:0]});
      end
      S_CRM: begin
        mul_a = MUL_W'(cr_u);
        mul_b = MUL_W'(cr_v);
      end
      S_OFM: begin
        mul_a = MUL_W'(s_val);
        mul_b = MUL_W'(b1[cidx]);
      end
      S_OFT: begin
        mul_a = MUL_W'(c_val);
        mul_b = MUL_W'(b2[cidx]);
      end
      S_OFR: begin
        mul_a = MUL_W'({1'b0, rad});
        mul_b = t_acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // square root step: two radicand bits a cycle
  always_comb begin
    rem_sh   = {sq_rem[33:0], sq_src[63:62]};
    sq_trial = {2'b00, sq_res, 2'b01};
    sq_ge    = (rem_sh >= sq_trial);
  end

  // divider step
  always_comb begin
    div_ge     = (div_rem >= div_dsh);
    div_rem_nx = div_ge ? div_rem - div_dsh : div_rem;
    div_q_nx   = {div_q[QUO_W-2:0], div_ge};
    div_unit   = neg[cidx] ? -UNIT_W'(div_q_nx) : UNIT_W'(div_q_nx);
  end

  // CORDIC shifts and result
  always_comb begin
    sh_x   = cy >>> ck;
    sh_y   = cx >>> ck;
    cs_q   = to_q14(cx);
    sn_q   = to_q14(cy);
    ph_sum = {1'b0, ph_r} + {1'b0, ph_r0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      subdivisions <= SUBDIV_W'(8);
      vertex_color <= '1;
      vtx_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SUBDIVISIONS: subdivisions <= cfg_data[SUBDIV_W-1:0];
          REG_VERTEX_COLOR: vertex_color <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end

      if (vtx_send) vtx_valid <= 1'b1;
      else if (!vtx_stall) vtx_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (seg_valid) begin
            pa[0]  <= start_x;
            pa[1]  <= start_y;
            pa[2]  <= start_z;
            pb[0]  <= end_x;
            pb[1]  <= end_y;
            pb[2]  <= end_z;
            rad    <= tube_radius;
            vin[0] <= VW'(end_x) - VW'(start_x);
            vin[1] <= VW'(end_y) - VW'(start_y);
            vin[2] <= VW'(end_z) - VW'(start_z);
            sel    <= V_DIR;
            state  <= S_ABS;
          end
        end

        S_ABS: begin
          for (int c = 0; c < 3; c++) begin
            neg[c] <= vin[c][VW-1];
            m[c]   <= vin[c][VW-1] ? MW'(-vin[c]) : MW'(vin[c]);
          end
          state <= S_NORM;
        end

        // scale so the largest part lies in [2^29, 2^30)
        S_NORM: begin
          if (mx == '0) begin
            state <= S_DEGEN;
          end else if (|mx[MW-1:30]) begin
            for (int c = 0; c < 3; c++) m[c] <= m[c] >> 1;
          end else if (!mx[29]) begin
            for (int c = 0; c < 3; c++) m[c] <= m[c] << 1;
          end else begin
            cidx   <= 2'd0;
            sum_sq <= '0;
            state  <= S_SQM;
          end
        end

        S_SQM: state <= S_SQA;

        S_SQA: begin
          sum_sq <= sum_sq + mul_p;
          if (cidx == 2'd2) begin
            sq_src <= sum_sq + mul_p;
            sq_rem <= '0;
            sq_res <= '0;
            sq_cnt <= '0;
            state  <= S_SQRT;
          end else begin
            cidx  <= cidx + 2'd1;
            state <= S_SQM;
          end
        end

        S_SQRT: begin
          sq_src <= sq_src << 2;
          sq_rem <= sq_ge ? rem_sh - sq_trial : rem_sh;
          sq_res <= {sq_res[30:0], sq_ge};
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd31) begin
            len       <= {sq_res[30:0], sq_ge};
            cidx      <= 2'd0;
            div_phase <= 1'b0;
            state     <= S_DIVI;
          end
        end

        S_DIVI: begin
          div_q <= '0;
          if (div_phase) begin
            div_rem <= DIV_W'(65536);
            div_dsh <= DIV_W'({n_eff, 16'b0});
            div_cnt <= 5'(QUO_W - 1);
          end else begin
            div_rem <= DIV_W'({m[cidx][29:0], 14'b0}) + DIV_W'(len >> 1);
            div_dsh <= DIV_W'({len, 14'b0});
            div_cnt <= 5'd14;
          end
          state <= S_DIV;
        end

        S_DIV: begin
          div_rem <= div_rem_nx;
          div_q   <= div_q_nx;
          div_dsh <= div_dsh >> 1;
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == '0) begin
            if (div_phase) begin
              ph_q0  <= div_q_nx;
              ph_r0  <= NW'(div_rem_nx);
              ph_q   <= '0;
              ph_r   <= n_eff >> 1;
              ring_i <= '0;
              state  <= S_CORI;
            end else begin
              case (sel)
                V_DIR:   vn[cidx] <= div_unit;
                V_B1:    b1[cidx] <= div_unit;
                default: b2[cidx] <= div_unit;
              endcase
              if (cidx == 2'd2) begin
                cidx <= 2'd0;
                term <= 1'b0;
                if (sel == V_B2) begin
                  div_phase <= 1'b1;
                  state     <= S_DIVI;
                end else begin
                  state <= S_CRM;
                end
              end else begin
                cidx  <= cidx + 2'd1;
                state <= S_DIVI;
              end
            end
          end
        end

        S_CRM: state <= S_CRA;

        S_CRA: begin
          if (!term) begin
            vin[cidx] <= VW'(mul_p);
            term      <= 1'b1;
            state     <= S_CRM;
          end else begin
            vin[cidx] <= vin[cidx] - VW'(mul_p);
            term      <= 1'b0;
            if (cidx == 2'd2) begin
              sel   <= (sel == V_DIR) ? V_B1 : V_B2;
              state <= S_ABS;
            end else begin
              cidx  <= cidx + 2'd1;
              state <= S_CRM;
            end
          end
        end

        S_CORI: begin
          cx    <= XY_W'(CORDIC_X0);
          cy    <= '0;
          cz    <= Z_W'({2'b00, ph_q[13:0]});
          quad  <= ph_q[15:14];
          ck    <= '0;
          state <= S_COR;
        end

        S_COR: begin
          if (!cz[Z_W-1]) begin
            cx <= cx - sh_x;
            cy <= cy + sh_y;
            cz <= cz - atan_turn(ck);
          end else begin
            cx <= cx + sh_x;
            cy <= cy - sh_y;
            cz <= cz + atan_turn(ck);
          end
          ck <= ck + 4'd1;
          if (ck == 4'(CORDIC_STEPS - 1)) state <= S_CORF;
        end

        S_CORF: begin
          case (quad)
            2'd0: begin c_val <= cs_q;  s_val <= sn_q;  end
            2'd1: begin c_val <= -sn_q; s_val <= cs_q;  end
            2'd2: begin c_val <= -cs_q; s_val <= -sn_q; end
            default: begin c_val <= sn_q; s_val <= -cs_q; end
          endcase
          // phase of the next ring step
          if (ph_sum >= {1'b0, n_eff}) begin
            ph_r <= NW'(ph_sum - {1'b0, n_eff});
            ph_q <= ph_q + ph_q0 + QUO_W'(1);
          end else begin
            ph_r <= NW'(ph_sum);
            ph_q <= ph_q + ph_q0;
          end
          cidx  <= 2'd0;
          state <= S_OFM;
        end

        S_OFM: state <= S_OFT;

        S_OFT: begin
          t_acc <= mul_p[31:0];
          state <= S_OFS;
        end

        S_OFS: begin
          t_acc <= t_acc + mul_p[31:0];
          state <= S_OFR;
        end

        S_OFR: state <= S_OFW;

        S_OFW: begin
          off[cidx] <= OFF_W'((mul_p + PROD_W'(134217728)) >>> 28);
          if (cidx == 2'd2) begin
            state <= S_OUT0;
          end else begin
            cidx  <= cidx + 2'd1;
            state <= S_OFM;
          end
        end

        S_OUT0: begin
          if (out_free) begin
            pos_x         <= sat_add(pa[0], off[0]);
            pos_y         <= sat_add(pa[1], off[1]);
            pos_z         <= sat_add(pa[2], off[2]);
            vertex_number <= VNUM_W'({ring_i, 1'b0});
            color_out     <= vertex_color;
            degenerate    <= 1'b0;
            last          <= 1'b0;
            state         <= S_OUT1;
          end
        end

        S_OUT1: begin
          if (out_free) begin
            pos_x         <= sat_add(pb[0], off[0]);
            pos_y         <= sat_add(pb[1], off[1]);
            pos_z         <= sat_add(pb[2], off[2]);
            vertex_number <= VNUM_W'({ring_i, 1'b1});
            color_out     <= vertex_color;
            degenerate    <= 1'b0;
            if (ring_i == n_eff - NW'(1)) begin
              last  <= 1'b1;
              state <= S_IDLE;
            end else begin
              last   <= 1'b0;
              ring_i <= ring_i + NW'(1);
              state  <= S_CORI;
            end
          end
        end

        S_DEGEN: begin
          if (out_free) begin
            pos_x         <= '0;
            pos_y         <= '0;
            pos_z         <= '0;
            vertex_number <= '0;
            color_out     <= vertex_color;
            degenerate    <= 1'b1;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `LCT_ASSERT_NEXT(a_seg_busy, clk, rst, seg_valid && !seg_stall, seg_stall)
  `LCT_ASSERT_NOW(a_degen_last, clk, rst, vtx_valid && degenerate, last && (vertex_number == '0))
  `LCT_ASSERT_NOW(a_ring_range, clk, rst, state == S_OUT1, ring_i < n_eff)
  `LCT_ASSERT_NOW(a_phase_rem, clk, rst, state == S_CORF, ph_r < n_eff)

endmodule
